// ----- rtl/imu_complementary_attitude_top_defines.svh -----
// ----------------------------------------------------------------------------
// IMU attitude estimator assertion macros
// Shared property wrappers for the estimator. They expect signals named clk
// and rst_n in the scope of use.
// ----------------------------------------------------------------------------
`ifndef IMU_COMPLEMENTARY_ATTITUDE_TOP_DEFINES_SVH
`define IMU_COMPLEMENTARY_ATTITUDE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ICA_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("attitude estimator check failed");

// Next-cycle implication, checked outside reset.
`define ICA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("attitude estimator check failed");

`endif

// ----- rtl/ica_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Attitude estimator package
// Types, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ica_pkg;

    // Angles are held in 2^-16 degree.
    localparam logic signed [27:0] HALF_TURN   = 28'sd11796480;
    localparam logic signed [27:0] FULL_TURN   = 28'sd23592960;
    // 180/pi and the CORDIC gain, both in Q16.
    localparam logic signed [23:0] RAD2DEG_Q16 = 24'sd3754936;
    localparam logic signed [23:0] GAIN_Q16    = 24'sd107922;

    // atan(2^-i) in 2^-16 degree.
    localparam logic [21:0] ATAN_TAB [32] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0
    };

    typedef enum logic [1:0] {
        REG_BLEND_WEIGHT  = 2'd0,
        REG_BIAS_RATE     = 2'd1,
        REG_STILL_LIMIT   = 2'd2,
        REG_SAMPLE_PERIOD = 2'd3
    } cfg_reg_t;

    localparam logic [15:0] BLEND_WEIGHT_RST  = 16'd64225;
    localparam logic [15:0] BIAS_RATE_RST     = 16'd33;
    localparam logic [14:0] STILL_LIMIT_RST   = 15'd205;
    localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd328;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_PGAIN,
        OP_PYSET,
        OP_CITER,
        OP_ROLL_END,
        OP_PITCH_END,
        OP_D_LOAD,
        OP_MUL_DSP,
        OP_T_LOAD,
        OP_MUL_TRAD,
        OP_ADD_DELTA,
        OP_MUL_W,
        OP_MUL_CW,
        OP_BLEND,
        OP_BIAS_DIFF,
        OP_BIAS_MUL,
        OP_BIAS_UPD,
        OP_WRAP,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [1:0] {
        AXIS_ROLL,
        AXIS_PITCH,
        AXIS_YAW
    } axis_t;

    typedef struct packed {
        dp_op_t      op;
        axis_t       axis;
        logic [4:0]  step;
    } dp_cmd_t;

    typedef struct packed {
        logic wrap_done;
    } dp_status_t;

endpackage

// ----- rtl/ica_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Attitude estimator channels
// Valid/ready channels for the IMU sample word and the attitude word.
// ----------------------------------------------------------------------------
interface ica_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic               motion_armed;

    modport source (
        output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, motion_armed,
        input  ready
    );
    modport sink (
        input  valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, motion_armed,
        output ready
    );
endinterface

interface ica_attitude_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] roll_angle;
    logic signed [14:0] pitch_angle;
    logic        [14:0] heading_angle;

    modport source (
        output valid, roll_angle, pitch_angle, heading_angle,
        input  ready
    );
    modport sink (
        input  valid, roll_angle, pitch_angle, heading_angle,
        output ready
    );
endinterface

// ----- rtl/ica_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Attitude estimator datapath
// Shared CORDIC vectoring stage, one shared multiplier, filter state and
// configuration registers, all stepped by the controller's commands.
// ----------------------------------------------------------------------------
module ica_datapath
    import ica_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] rate_x,
    input  logic signed [15:0] rate_y,
    input  logic signed [15:0] rate_z,
    input  logic               motion_armed,
    output logic signed [14:0] roll_angle,
    output logic signed [14:0] pitch_angle,
    output logic        [14:0] heading_angle
);

    function automatic logic [16:0] mag16(input logic signed [15:0] v);
        logic signed [16:0] e;
        e = {v[15], v};
        return (e < 0) ? 17'(-e) : 17'(e);
    endfunction

    // Configuration
    logic [15:0] w_reg, bias_rate_reg, sp_reg;
    logic [14:0] lim_reg;

    // Sample word
    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg, gz_reg;
    logic               armed_reg;

    // CORDIC
    logic signed [33:0] cx_reg, cy_reg, pitch_y_reg;
    logic signed [27:0] cz_reg;
    logic               zero_reg;
    logic signed [24:0] roll_acc_reg, pitch_acc_reg;

    // Gyro and blend arithmetic
    logic signed [57:0] prod_reg;
    logic signed [33:0] diff_reg, t_reg;
    logic signed [27:0] sum_reg;
    logic signed [43:0] acc_reg;

    // Filter state
    logic signed [24:0] roll_est_reg, pitch_est_reg;
    logic signed [31:0] bias_reg;
    logic        [24:0] yaw_est_reg;

    logic signed [14:0] roll_out_reg, pitch_out_reg;
    logic        [14:0] heading_out_reg;

    // ---- shared multiplier ----
    logic signed [33:0] mul_a;
    logic signed [23:0] mul_b;
    logic signed [57:0] mul_p;
    logic        [16:0] cw;

    assign cw = 17'(17'd65536 - {1'b0, w_reg});

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_PGAIN:
            begin
                mul_a = -34'(ax_reg);
                mul_b = GAIN_Q16;
            end
            OP_MUL_DSP:
            begin
                mul_a = diff_reg;
                mul_b = $signed({8'd0, sp_reg});
            end
            OP_BIAS_MUL:
            begin
                mul_a = diff_reg;
                mul_b = $signed({8'd0, bias_rate_reg});
            end
            OP_MUL_TRAD:
            begin
                mul_a = t_reg;
                mul_b = RAD2DEG_Q16;
            end
            OP_MUL_W:
            begin
                mul_a = 34'(sum_reg);
                mul_b = $signed({8'd0, w_reg});
            end
            OP_MUL_CW:
            begin
                mul_a = (cmd.axis == AXIS_PITCH) ? 34'(pitch_acc_reg) : 34'(roll_acc_reg);
                mul_b = $signed({7'd0, cw});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ---- rounding shifts of the product ----
    logic signed [57:0] r16, r28, r2;
    logic signed [33:0] shr16;
    logic signed [27:0] delta;
    logic signed [33:0] pitch_y_next;

    assign r16          = prod_reg + 58'sd32768;
    assign shr16        = r16[49:16];
    assign r28          = prod_reg + 58'sd134217728;
    assign delta        = r28[55:28];
    assign r2           = prod_reg + 58'sd2;
    assign pitch_y_next = r2[35:2];

    // ---- gyro difference and estimate selects ----
    logic signed [33:0] yaw_diff, d_sel;
    logic signed [27:0] est_sel;

    assign yaw_diff = 34'($signed({gz_reg, 16'h0000})) - 34'(bias_reg);

    always_comb
    begin
        unique case (cmd.axis)
            AXIS_ROLL:
            begin
                d_sel   = 34'($signed({gx_reg, 16'h0000}));
                est_sel = 28'(roll_est_reg);
            end
            AXIS_PITCH:
            begin
                d_sel   = 34'($signed({gy_reg, 16'h0000}));
                est_sel = 28'(pitch_est_reg);
            end
            AXIS_YAW:
            begin
                d_sel   = yaw_diff;
                est_sel = $signed({3'b000, yaw_est_reg});
            end
            default:
            begin
                d_sel   = '0;
                est_sel = '0;
            end
        endcase
    end

    // ---- blend result ----
    logic signed [43:0] bsum, bround;
    logic signed [27:0] bshift;
    logic signed [24:0] blend_clamped;

    assign bsum   = acc_reg + $signed(prod_reg[43:0]);
    assign bround = bsum + 44'sd32768;
    assign bshift = bround[43:16];

    always_comb
    begin
        priority if (bshift > HALF_TURN)
            blend_clamped = 25'(HALF_TURN);
        else if (bshift < -HALF_TURN)
            blend_clamped = 25'(-HALF_TURN);
        else
            blend_clamped = bshift[24:0];
    end

    // ---- bias learning ----
    logic               still;
    logic signed [33:0] bias_sum;

    assign still = !armed_reg
                   && (mag16(gx_reg) < {2'b00, lim_reg})
                   && (mag16(gy_reg) < {2'b00, lim_reg})
                   && (mag16(gz_reg) < {2'b00, lim_reg});
    assign bias_sum = 34'(bias_reg) + shr16;

    // ---- CORDIC start and step ----
    logic signed [33:0] x0, y0, xs, ys;
    logic signed [27:0] at, z_clamped;
    logic               init_zero;
    logic signed [24:0] cordic_angle;

    always_comb
    begin
        if (cmd.op == OP_ROLL_END)
        begin
            x0 = zero_reg ? '0 : cx_reg;
            y0 = pitch_y_reg;
        end
        else
        begin
            x0 = 34'($signed({az_reg, 14'h0000}));
            y0 = 34'($signed({ay_reg, 14'h0000}));
        end
    end

    assign init_zero = (x0 == '0) && (y0 == '0);
    assign xs        = cx_reg >>> cmd.step;
    assign ys        = cy_reg >>> cmd.step;
    assign at        = $signed({6'd0, ATAN_TAB[cmd.step]});

    always_comb
    begin
        priority if (cz_reg > HALF_TURN)
            z_clamped = HALF_TURN;
        else if (cz_reg < -HALF_TURN)
            z_clamped = -HALF_TURN;
        else
            z_clamped = cz_reg;
    end

    assign cordic_angle = zero_reg ? '0 : z_clamped[24:0];

    // ---- heading wrap ----
    logic yaw_high, yaw_low;
    assign yaw_high         = sum_reg > FULL_TURN;
    assign yaw_low          = sum_reg < 0;
    assign status.wrap_done = !yaw_high && !yaw_low;

    // ---- output rounding ----
    logic signed [24:0] roll_rnd, pitch_rnd;
    logic        [25:0] yaw_rnd;

    assign roll_rnd  = roll_est_reg + 25'sd512;
    assign pitch_rnd = pitch_est_reg + 25'sd512;
    assign yaw_rnd   = {1'b0, sum_reg[24:0]} + 26'd512;

    // ---- state and configuration registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg         <= BLEND_WEIGHT_RST;
            bias_rate_reg <= BIAS_RATE_RST;
            lim_reg       <= STILL_LIMIT_RST;
            sp_reg        <= SAMPLE_PERIOD_RST;
            roll_est_reg  <= '0;
            pitch_est_reg <= '0;
            bias_reg      <= '0;
            yaw_est_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BLEND_WEIGHT:  w_reg         <= cfg_data;
                    REG_BIAS_RATE:     bias_rate_reg <= cfg_data;
                    REG_STILL_LIMIT:   lim_reg       <= cfg_data[14:0];
                    REG_SAMPLE_PERIOD: sp_reg        <= cfg_data;
                endcase
            end
            if (cmd.op == OP_BLEND)
            begin
                if (cmd.axis == AXIS_PITCH)
                    pitch_est_reg <= blend_clamped;
                else
                    roll_est_reg <= blend_clamped;
            end
            if (cmd.op == OP_BIAS_UPD && still)
                bias_reg <= bias_sum[31:0];
            if (cmd.op == OP_EMIT)
                yaw_est_reg <= sum_reg[24:0];
        end
    end

    // ---- working registers ----
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                ax_reg    <= accel_x;
                ay_reg    <= accel_y;
                az_reg    <= accel_z;
                gx_reg    <= rate_x;
                gy_reg    <= rate_y;
                gz_reg    <= rate_z;
                armed_reg <= motion_armed;
            end
            OP_PGAIN, OP_ROLL_END:
            begin
                if (cmd.op == OP_PGAIN)
                    prod_reg <= mul_p;
                else
                    roll_acc_reg <= cordic_angle;
                zero_reg <= init_zero;
                if (x0 < 0)
                begin
                    cx_reg <= -x0;
                    cy_reg <= -y0;
                    cz_reg <= (y0 >= 0) ? HALF_TURN : -HALF_TURN;
                end
                else
                begin
                    cx_reg <= x0;
                    cy_reg <= y0;
                    cz_reg <= '0;
                end
            end
            OP_PYSET:     pitch_y_reg <= pitch_y_next;
            OP_CITER:
            begin
                if (cy_reg > 0)
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + at;
                end
                else
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - at;
                end
            end
            OP_PITCH_END: pitch_acc_reg <= cordic_angle;
            OP_D_LOAD:    diff_reg <= d_sel;
            OP_BIAS_DIFF: diff_reg <= yaw_diff;
            OP_MUL_DSP, OP_MUL_TRAD, OP_MUL_W, OP_BIAS_MUL:
                prod_reg <= mul_p;
            OP_MUL_CW:
            begin
                acc_reg  <= $signed(prod_reg[43:0]);
                prod_reg <= mul_p;
            end
            OP_T_LOAD:    t_reg <= shr16;
            OP_ADD_DELTA: sum_reg <= est_sel + delta;
            OP_WRAP:
            begin
                if (yaw_high)
                    sum_reg <= sum_reg - FULL_TURN;
                else if (yaw_low)
                    sum_reg <= sum_reg + FULL_TURN;
            end
            OP_EMIT:
            begin
                roll_out_reg    <= roll_rnd[24:10];
                pitch_out_reg   <= pitch_rnd[24:10];
                heading_out_reg <= yaw_rnd[24:10];
            end
            default:
            begin
            end
        endcase
    end

    assign roll_angle    = roll_out_reg;
    assign pitch_angle   = pitch_out_reg;
    assign heading_angle = heading_out_reg;

endmodule

// ----- rtl/ica_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Attitude estimator controller
// Sequences the CORDIC passes, the per-axis filter steps and the result word.
// ----------------------------------------------------------------------------
module ica_ctrl
    import ica_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    localparam int IW = $clog2(CORDIC_STEPS);
    localparam logic [IW-1:0] LAST_STEP = IW'(CORDIC_STEPS - 1);

    typedef enum logic [19:0] {
        S_IDLE      = 20'h00001,
        S_PGAIN     = 20'h00002,
        S_PYSET     = 20'h00004,
        S_ROLL_IT   = 20'h00008,
        S_ROLL_END  = 20'h00010,
        S_PITCH_IT  = 20'h00020,
        S_PITCH_END = 20'h00040,
        S_D_LOAD    = 20'h00080,
        S_MUL_DSP   = 20'h00100,
        S_T_LOAD    = 20'h00200,
        S_MUL_TRAD  = 20'h00400,
        S_ADD_DELTA = 20'h00800,
        S_MUL_W     = 20'h01000,
        S_MUL_CW    = 20'h02000,
        S_BLEND     = 20'h04000,
        S_BIAS_DIFF = 20'h08000,
        S_BIAS_MUL  = 20'h10000,
        S_BIAS_UPD  = 20'h20000,
        S_WRAP      = 20'h40000,
        S_EMIT      = 20'h80000
    } state_t;

    state_t          state_reg, state_next;
    axis_t           axis_reg, axis_next;
    logic [IW-1:0]   cnt_reg, cnt_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_IDLE;
        cmd.axis       = axis_reg;
        cmd.step       = 5'(cnt_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_PGAIN;
                end
            end
            S_PGAIN:
            begin
                cmd.op     = OP_PGAIN;
                state_next = S_PYSET;
            end
            S_PYSET:
            begin
                cmd.op     = OP_PYSET;
                cnt_next   = '0;
                state_next = S_ROLL_IT;
            end
            S_ROLL_IT:
            begin
                cmd.op = OP_CITER;
                if (cnt_reg == LAST_STEP)
                    state_next = S_ROLL_END;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_ROLL_END:
            begin
                cmd.op     = OP_ROLL_END;
                cnt_next   = '0;
                state_next = S_PITCH_IT;
            end
            S_PITCH_IT:
            begin
                cmd.op = OP_CITER;
                if (cnt_reg == LAST_STEP)
                    state_next = S_PITCH_END;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_PITCH_END:
            begin
                cmd.op     = OP_PITCH_END;
                axis_next  = AXIS_ROLL;
                state_next = S_D_LOAD;
            end
            S_D_LOAD:
            begin
                cmd.op     = OP_D_LOAD;
                state_next = S_MUL_DSP;
            end
            S_MUL_DSP:
            begin
                cmd.op     = OP_MUL_DSP;
                state_next = S_T_LOAD;
            end
            S_T_LOAD:
            begin
                cmd.op     = OP_T_LOAD;
                state_next = S_MUL_TRAD;
            end
            S_MUL_TRAD:
            begin
                cmd.op     = OP_MUL_TRAD;
                state_next = S_ADD_DELTA;
            end
            S_ADD_DELTA:
            begin
                cmd.op     = OP_ADD_DELTA;
                state_next = (axis_reg == AXIS_YAW) ? S_WRAP : S_MUL_W;
            end
            S_MUL_W:
            begin
                cmd.op     = OP_MUL_W;
                state_next = S_MUL_CW;
            end
            S_MUL_CW:
            begin
                cmd.op     = OP_MUL_CW;
                state_next = S_BLEND;
            end
            S_BLEND:
            begin
                cmd.op = OP_BLEND;
                if (axis_reg == AXIS_ROLL)
                begin
                    axis_next  = AXIS_PITCH;
                    state_next = S_D_LOAD;
                end
                else
                    state_next = S_BIAS_DIFF;
            end
            S_BIAS_DIFF:
            begin
                cmd.op     = OP_BIAS_DIFF;
                state_next = S_BIAS_MUL;
            end
            S_BIAS_MUL:
            begin
                cmd.op     = OP_BIAS_MUL;
                state_next = S_BIAS_UPD;
            end
            S_BIAS_UPD:
            begin
                cmd.op     = OP_BIAS_UPD;
                axis_next  = AXIS_YAW;
                state_next = S_D_LOAD;
            end
            S_WRAP:
            begin
                cmd.op = OP_WRAP;
                if (status.wrap_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.op         = OP_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= AXIS_ROLL;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/imu_complementary_attitude_top.sv -----
`timescale 1ns / 1ps
// A sample is accepted only while the controller is idle, so no new sample is taken before the
// result word of the last one is loaded, and loading waits while an older word is still waiting.
// The CORDIC passes, the shared multiplier and the heading wrap, repeated until in range, set the time.
// Reset clears the estimates, the learned bias and the result valid flag, and
// returns the configuration registers to their documented defaults.
// ----------------------------------------------------------------------------
// IMU complementary attitude estimator
// Roll and pitch from accelerometer CORDIC angles blended with the integrated
// gyro rates; heading integrated from the bias-corrected z rate.
// ----------------------------------------------------------------------------
`include "imu_complementary_attitude_top_defines.svh"

module imu_complementary_attitude_top
    import ica_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [15:0]    cfg_data,
    ica_sample_if.sink     sample,
    ica_attitude_if.source attitude
);

    // The controller owns the handshakes and the sequence of steps; the
    // datapath owns every arithmetic register and the filter state. They
    // talk only through the command word and the status word.
    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_ready;
    logic       out_valid;

    ica_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (attitude.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // The result word sits in the datapath's output registers, so the sample
    // side is free again as soon as the word is loaded, even if the consumer
    // has not yet taken it.
    ica_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .status        (status),
        .accel_x       (sample.accel_x),
        .accel_y       (sample.accel_y),
        .accel_z       (sample.accel_z),
        .rate_x        (sample.rate_x),
        .rate_y        (sample.rate_y),
        .rate_z        (sample.rate_z),
        .motion_armed  (sample.motion_armed),
        .roll_angle    (attitude.roll_angle),
        .pitch_angle   (attitude.pitch_angle),
        .heading_angle (attitude.heading_angle)
    );

    assign sample.ready   = in_ready;
    assign attitude.valid = out_valid;

    // Once a sample is taken the block is busy until the result is loaded.
    `ICA_ASSERT_NEXT(a_accept_busy, sample.valid && sample.ready, !sample.ready)
    // Loading the result word always raises valid on the next cycle.
    `ICA_ASSERT_NEXT(a_emit_valid, cmd.op == OP_EMIT, attitude.valid)
    // Presented angles stay inside the saturation and wrap limits.
    `ICA_ASSERT_IMPLIES(a_out_range, attitude.valid, (attitude.heading_angle <= 15'd23040) && (attitude.roll_angle <= 15'sd11520) && (attitude.roll_angle >= -15'sd11520) && (attitude.pitch_angle <= 15'sd11520) && (attitude.pitch_angle >= -15'sd11520))

endmodule
